### hw/rtl/l2h_pkg.sv
// ----------------------------------------------------------------------------
// l2h_pkg: shared types and constants of the lookup2 string hash
// Mixing word type, job format passed from front to back, round function.
// ----------------------------------------------------------------------------
package l2h_pkg;

   localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
   localparam int          BLOCK_SIZE  = 12;
   localparam int          FILL_W      = 4;
   localparam logic [3:0]  ROUND_LAST  = 4'd8;
   localparam int          QDEPTH      = 2;
   localparam int          QPTR_W      = 1;
   localparam int          QCNT_W      = 2;

   // What the back does with a job
   typedef enum logic [1:0] {
      OP_BLOCK,        // add block words, mix
      OP_FINAL,        // add tail words (length already in c), mix, emit
      OP_BLOCK_FINAL   // add block words, mix, add length to c, mix, emit
   } op_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } mix_type;

   typedef struct packed {
      op_type      op;
      mix_type     words;
      logic [31:0] length;
   } job_type;

   // One line of the mix: three subtract/xor lines per word, nine in all
   function automatic mix_type mix_round(input mix_type m, input logic [3:0] r);
      mix_type o;
      o = m;
      unique case (r)
         4'd0: o.a = (m.a - m.b - m.c) ^ (m.c >> 13);
         4'd1: o.b = (m.b - m.c - m.a) ^ (m.a << 8);
         4'd2: o.c = (m.c - m.a - m.b) ^ (m.b >> 13);
         4'd3: o.a = (m.a - m.b - m.c) ^ (m.c >> 12);
         4'd4: o.b = (m.b - m.c - m.a) ^ (m.a << 16);
         4'd5: o.c = (m.c - m.a - m.b) ^ (m.b >> 5);
         4'd6: o.a = (m.a - m.b - m.c) ^ (m.c >> 3);
         4'd7: o.b = (m.b - m.c - m.a) ^ (m.a << 10);
         4'd8: o.c = (m.c - m.a - m.b) ^ (m.b >> 15);
         default: o = m;
      endcase
      return o;
   endfunction

endpackage

### hw/rtl/l2h_front.sv
// ----------------------------------------------------------------------------
// l2h_front: byte collector
// Gathers key bytes into a 12-byte block, counts the key length and turns
// each full block and each key end into a job for the mixing back end.
// ----------------------------------------------------------------------------
module l2h_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_no_byte,
   input  logic              req_last,
   output logic              push,
   output l2h_pkg::job_type  push_job,
   input  logic              q_full
);
   import l2h_pkg::*;

   logic [7:0]        buf_ff [BLOCK_SIZE];
   logic [7:0]        buf_in [BLOCK_SIZE];
   logic [7:0]        kept   [BLOCK_SIZE];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] fill_next;
   logic [31:0]       len_ff;
   logic [31:0]       len_in;
   logic [31:0]       len_next;
   logic              accept;
   logic              blk_full;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Place the new byte and count it
   always_comb begin
      for (int i = 0; i < BLOCK_SIZE; i++) begin
         buf_in[i] = buf_ff[i];
         if (accept && !req_no_byte && fill_ff == FILL_W'(i)) begin
            buf_in[i] = req_data_byte;
         end
      end
      fill_next = fill_ff + FILL_W'(!req_no_byte);
      len_next  = len_ff + 32'(!req_no_byte);
      blk_full  = (fill_next == FILL_W'(BLOCK_SIZE));
      for (int i = 0; i < BLOCK_SIZE; i++) begin
         kept[i] = (FILL_W'(i) < fill_next) ? buf_in[i] : 8'h00;
      end
   end

   // Build the job: full block, or tail with the length in c's low byte
   always_comb begin
      push            = accept && (req_last || blk_full);
      push_job.length = len_next;
      push_job.words.a = {kept[3], kept[2], kept[1], kept[0]};
      push_job.words.b = {kept[7], kept[6], kept[5], kept[4]};
      if (blk_full) begin
         push_job.words.c = {kept[11], kept[10], kept[9], kept[8]};
         push_job.op      = req_last ? OP_BLOCK_FINAL : OP_BLOCK;
      end else begin
         push_job.words.c = {kept[10], kept[9], kept[8], 8'h00} + len_next;
         push_job.op      = OP_FINAL;
      end
   end

   // Advance fill and length; a key end starts a new key
   always_comb begin
      fill_in = fill_ff;
      len_in  = len_ff;
      if (accept) begin
         if (req_last) begin
            fill_in = '0;
            len_in  = '0;
         end else begin
            fill_in = blk_full ? '0 : fill_next;
            len_in  = len_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BLOCK_SIZE; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

endmodule

### hw/rtl/l2h_queue.sv
// ----------------------------------------------------------------------------
// l2h_queue: two-entry job queue
// Decouples the byte collector from the mixing back end.
// ----------------------------------------------------------------------------
module l2h_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  l2h_pkg::job_type  push_job,
   output logic              q_full,
   output logic              q_valid,
   output l2h_pkg::job_type  q_job,
   input  logic              pop
);
   import l2h_pkg::*;

   job_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign q_full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_valid = (count_ff != '0);
   assign q_job   = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hw/rtl/l2h_back.sv
// ----------------------------------------------------------------------------
// l2h_back: mixing engine
// Holds a, b, c; adds each job's words and runs the mix one line per cycle
// on a shared round unit; emits c into the result register at key end.
// ----------------------------------------------------------------------------
module l2h_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  l2h_pkg::job_type  q_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_hash_value
);
   import l2h_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MIX,
      BK_LEN,
      BK_EMIT
   } bk_state_type;

   bk_state_type state_ff;
   bk_state_type state_in;
   mix_type      mix_ff;
   mix_type      mix_in;
   op_type       op_ff;
   op_type       op_in;
   logic [31:0]  len_ff;
   logic [31:0]  len_in;
   logic [3:0]   round_ff;
   logic [3:0]   round_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic [31:0]  out_hash_ff;
   logic [31:0]  out_hash_in;

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

   // Next state, datapath and result register
   always_comb begin
      state_in     = state_ff;
      mix_in       = mix_ff;
      op_in        = op_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      pop          = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_hash_in  = out_hash_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               mix_in.a = mix_ff.a + q_job.words.a;
               mix_in.b = mix_ff.b + q_job.words.b;
               mix_in.c = mix_ff.c + q_job.words.c;
               op_in    = q_job.op;
               len_in   = q_job.length;
               round_in = '0;
               state_in = BK_MIX;
            end
         end
         BK_MIX: begin
            mix_in   = mix_round(mix_ff, round_ff);
            round_in = round_ff + 4'd1;
            if (round_ff == ROUND_LAST) begin
               unique case (op_ff)
                  OP_BLOCK:       state_in = BK_IDLE;
                  OP_BLOCK_FINAL: state_in = BK_LEN;
                  OP_FINAL:       state_in = BK_EMIT;
                  default:        state_in = BK_IDLE;
               endcase
            end
         end
         BK_LEN: begin
            // empty tail after a full last block: only the length goes in
            mix_in.c = mix_ff.c + len_ff;
            op_in    = OP_FINAL;
            round_in = '0;
            state_in = BK_MIX;
         end
         BK_EMIT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_hash_in  = mix_ff.c;
               mix_in.a     = GOLDEN_WORD;
               mix_in.b     = GOLDEN_WORD;
               mix_in.c     = '0;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         mix_ff.a     <= GOLDEN_WORD;
         mix_ff.b     <= GOLDEN_WORD;
         mix_ff.c     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         mix_ff       <= mix_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      len_ff      <= len_in;
      round_ff    <= round_in;
      out_hash_ff <= out_hash_in;
   end

endmodule

### hw/rtl/lookup2_string_hash.sv
// ----------------------------------------------------------------------------
// lookup2_string_hash: 32-bit lookup2 hash of a byte-stream key
// Front collector, two-entry job queue and iterative mixing back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one key byte per item; req_last marks the key's final
//   item, and req_no_byte marks an item without a byte (an empty key is a
//   single item with both set). rsp_* carries one hash per key.
//   Bytes are taken one per cycle while the job queue is not full. Every
//   12th byte and every last item becomes a job; the back end adds the
//   job's words and then runs the mix (one mix line per cycle on a single
//   round unit), and full blocks keep pace with a byte per cycle.
//   A last byte that fills a block costs two mixes. The back end takes a
//   new job from the queue only once it has finished the job before, so
//   short keys run at a pace set by the round unit.
//   req_stall rises while the job queue is full; rsp_stall holds the
//   result register and the back end waits at its emit step.
//   Synchronous reset empties the queue, drops any pending result and
//   restores the initial mixing words; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lookup2_string_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_no_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);
   import l2h_pkg::*;

   logic    push;
   job_type push_job;
   logic    q_full;
   logic    q_valid;
   job_type q_job;
   logic    pop;

   l2h_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_no_byte   (req_no_byte),
      .req_last      (req_last),
      .push          (push),
      .push_job      (push_job),
      .q_full        (q_full)
   );

   l2h_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_job    (q_job),
      .pop      (pop)
   );

   l2h_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_job          (q_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

### hw/rtl/l2h_checker.sv
// ----------------------------------------------------------------------------
// l2h_checker: port-level checks of the lookup2 string hash
// Watches both channels; counts keys ended but not yet answered.
// ----------------------------------------------------------------------------
module l2h_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_hash_value
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       key_end;
   logic       rsp_take;

   assign key_end  = req_valid && !req_stall && req_last;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Track keys ended whose hash is still owed
   always_comb begin
      pending_in = pending_ff + 3'(key_end) - 3'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result changed or dropped");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without an ended key");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind lookup2_string_hash l2h_checker u_l2h_checker (.*);

### tb/sv/l2h_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// l2h_tb_pkg: hash scoreboard for the lookup2 string hash testbench
// Tracks the mixing words, the partial block and the key length of each key
// that goes in. It queues the expected hash of every finished key and checks
// the block's results against that queue in order.
// ----------------------------------------------------------------------------
package l2h_tb_pkg;

   import l2h_pkg::GOLDEN_WORD;
   import l2h_pkg::BLOCK_SIZE;

   class hash_scoreboard;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [7:0]  block_buf [BLOCK_SIZE];
      int unsigned fill;
      logic [31:0] key_len;
      logic [31:0] pending_hashes [$];
      int unsigned mismatches;
      int unsigned hashes_checked;
      int unsigned keys_done;

      function new();
         restart();
         mismatches     = 0;
         hashes_checked = 0;
         keys_done      = 0;
      endfunction

      // Return to the state of a fresh key
      function void restart();
         word_a  = GOLDEN_WORD;
         word_b  = GOLDEN_WORD;
         word_c  = 32'd0;
         fill    = 0;
         key_len = 32'd0;
      endfunction

      // Run the nine subtract/xor/shift lines over a, b and c
      function void churn();
         word_a = (word_a - word_b - word_c) ^ (word_c >> 13);
         word_b = (word_b - word_c - word_a) ^ (word_a << 8);
         word_c = (word_c - word_a - word_b) ^ (word_b >> 13);
         word_a = (word_a - word_b - word_c) ^ (word_c >> 12);
         word_b = (word_b - word_c - word_a) ^ (word_a << 16);
         word_c = (word_c - word_a - word_b) ^ (word_b >> 5);
         word_a = (word_a - word_b - word_c) ^ (word_c >> 3);
         word_b = (word_b - word_c - word_a) ^ (word_a << 10);
         word_c = (word_c - word_a - word_b) ^ (word_b >> 15);
      endfunction

      // Fold one accepted item into the running hash
      function void note_item(input logic [7:0] value, input logic carries_none,
                              input logic ends_key);
         int unsigned k;
         logic [31:0] wide;
         if (!carries_none) begin
            block_buf[fill] = value;
            fill++;
            key_len++;
            // full block: add it little-endian and mix
            if (fill == BLOCK_SIZE) begin
               word_a += {block_buf[3], block_buf[2], block_buf[1], block_buf[0]};
               word_b += {block_buf[7], block_buf[6], block_buf[5], block_buf[4]};
               word_c += {block_buf[11], block_buf[10], block_buf[9], block_buf[8]};
               churn();
               fill = 0;
            end
         end
         if (ends_key) begin
            // length goes into c's low byte, tail bytes of c sit one byte up
            word_c += key_len;
            for (k = 0; k < fill; k++) begin
               wide = {24'd0, block_buf[k]};
               if (k < 4)
                  word_a += wide << (8 * (k % 4));
               else if (k < 8)
                  word_b += wide << (8 * (k % 4));
               else
                  word_c += wide << (8 * (k % 4) + 8);
            end
            churn();
            pending_hashes.push_back(word_c);
            keys_done++;
            restart();
         end
      endfunction

      // Compare one result with the oldest pending hash
      function void check_hash(input logic [31:0] actual);
         logic [31:0] wanted;
         if (pending_hashes.size() == 0) begin
            $display("%0t: unexpected hash, expected none, actual %08h", $time, actual);
            mismatches++;
         end else begin
            wanted = pending_hashes.pop_front();
            hashes_checked++;
            if (actual !== wanted) begin
               $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                        $time, wanted, actual);
               mismatches++;
            end
         end
      endfunction
   endclass

endpackage

### tb/sv/lookup2_string_hash_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lookup2_string_hash_tb: key-stream testbench of the lookup2 string hash
// Feeds keys one byte per item with random gaps and result stalls, predicts
// each key's hash in a scoreboard and checks every result in order.
// ----------------------------------------------------------------------------
module lookup2_string_hash_tb;

   import l2h_tb_pkg::*;

   localparam int  ITEM_TARGET = 1650;
   localparam int  IDLE_PCT    = 21;
   localparam int  SETTLE      = 30;
   localparam int  HANG_LIMIT  = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_no_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_hash_value;

   hash_scoreboard sb;
   bit          quiet = 1'b0;
   int unsigned bytes_sent = 0;
   int unsigned byteless_sent = 0;
   int unsigned counted_items = 0;
   int unsigned hang_count = 0;

   lookup2_string_hash u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_no_byte    (req_no_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   always #10 clock = ~clock;

   // Stall the result side at random, except in the quiet stretch
   always @(negedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_hash(rsp_hash_value);
   end

   // Count cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
         $display("lookup2_string_hash_tb NOT OK");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

   // Offer one item, called and returning at a falling edge
   task automatic send_item(input logic [7:0] value, input logic carries_none,
                            input logic ends_key);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_no_byte   <= carries_none;
      req_last      <= ends_key;
      do @(posedge clock); while (req_stall);
      sb.note_item(value, carries_none, ends_key);
      if (carries_none)
         byteless_sent++;
      else
         bytes_sent++;
      counted_items++;
      @(negedge clock);
   endtask

   // Hold the sender until every pending hash has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending_hashes.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Send a key of random bytes, with stray byteless items mixed in
   task automatic send_key(input int unsigned n_bytes, input bit byteless_end);
      int unsigned k;
      for (k = 0; k < n_bytes; k++) begin
         if ($urandom_range(99) < 8)
            send_item(8'($urandom), 1'b1, 1'b0);
         send_item(8'($urandom), 1'b0, !byteless_end && (k == n_bytes - 1));
      end
      if (byteless_end || n_bytes == 0)
         send_item(8'($urandom), 1'b1, 1'b1);
   endtask

   initial begin
      int unsigned k;
      int unsigned key_no;
      int unsigned pick;
      int unsigned n;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty key
      send_item(8'h00, 1'b1, 1'b1);
      // byteless item that is not last, then a one-byte key
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      // last byte fills the block
      for (k = 0; k < 12; k++)
         send_item(k[0] ? 8'h00 : 8'hff, 1'b0, k == 11);
      // byteless last item after bytes
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'h7f, 1'b0, 1'b0);
      send_item(8'h01, 1'b0, 1'b0);
      send_item(8'h5a, 1'b1, 1'b1);
      drain_results();

      // Random keys: mostly short, some long, some whole blocks
      key_no = 0;
      while (counted_items < ITEM_TARGET) begin
         quiet = (key_no >= 30 && key_no < 45);
         if (key_no == 60)
            drain_results();
         pick = $urandom_range(99);
         if (pick < 65)
            n = $urandom_range(24);
         else if (pick < 85)
            n = $urandom_range(60, 25);
         else
            n = 12 * $urandom_range(4, 1);
         send_key(n, $urandom_range(99) < 20);
         key_no++;
      end
      quiet = 1'b0;

      // Let every hash come out, then watch for strays
      drain_results();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d keys: %0d key bytes and %0d byteless items sent,",
               sb.keys_done, bytes_sent, byteless_sent);
      $display("%0d hashes checked, %0d mismatches", sb.hashes_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_hashes.size() == 0) begin
         $display("lookup2_string_hash_tb OK");
      end else begin
         $display("lookup2_string_hash_tb NOT OK");
      end
      $finish;
   end

endmodule
